// ----- src/hled_pkg.sv -----
// ----------------------------------------------------------------------------
// hled_pkg
// shared types and constants of the horizontal line event detector
// ----------------------------------------------------------------------------
`default_nettype none

package hled_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROI_FIRST_ROW   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THRESHOLD  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MID_THRESHOLD   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN_FRAMES = 4'd3;

  localparam int ROW_CFG_W  = 10;
  localparam int THR_W      = 18;
  localparam int COOLDOWN_W = 6;

  localparam logic [ROW_CFG_W-1:0]  ROI_FIRST_ROW_RESET   = 10'd320;
  localparam logic [THR_W-1:0]      HIGH_THRESHOLD_RESET  = 18'd352;
  localparam logic [THR_W-1:0]      MID_THRESHOLD_RESET   = 18'd256;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_FRAMES_RESET = 6'd45;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_THIN_LINE = 2'd1,
    EV_WIDE_BAND = 2'd2
  } event_code_t;

  typedef struct packed {
    logic [ROW_CFG_W-1:0]  roi_first_row;
    logic [THR_W-1:0]      high_threshold;
    logic [THR_W-1:0]      mid_threshold;
    logic [COOLDOWN_W-1:0] cooldown_frames;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       frame_end;
  } pixel_item_t;

  // per-frame summary handed from the row accumulator to the decision stage
  typedef struct packed {
    logic done;
    logic strong_one_two;
    logic medium_le_two;
    logic medium_ge_four;
  } frame_stat_t;

endpackage

`default_nettype wire

// ----- src/hled_in_reg.sv -----
// ----------------------------------------------------------------------------
// hled_in_reg
// input register with flow control toward the result register
// ----------------------------------------------------------------------------
`default_nettype none

module hled_in_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hled_pkg::pixel_item_t in_item,
  input  wire logic                 out_free,
  output hled_pkg::pixel_item_t     stage_item,
  output logic                      step
);

  logic stage_valid;

  // only a frame end needs a free result slot
  assign step     = stage_valid && (!stage_item.frame_end || out_free);
  assign in_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/hled_row_acc.sv -----
// ----------------------------------------------------------------------------
// hled_row_acc
// row sum, row index and saturating strong / medium row counters
// ----------------------------------------------------------------------------
`default_nettype none

module hled_row_acc #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire hled_pkg::pixel_item_t item,
  input  wire hled_pkg::cfg_t        cfg,
  output hled_pkg::frame_stat_t      stat
);

  localparam int SUM_LIMIT_V = MAX_WIDTH * 255;
  localparam int SUM_W  = $clog2(SUM_LIMIT_V + 1);
  localparam int IDX_W  = $clog2(MAX_HEIGHT);
  localparam int CMPS_W = (SUM_W > hled_pkg::THR_W) ? SUM_W : hled_pkg::THR_W;
  localparam int CMPI_W = (IDX_W > hled_pkg::ROW_CFG_W) ? IDX_W : hled_pkg::ROW_CFG_W;
  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(SUM_LIMIT_V);
  localparam logic [IDX_W-1:0] ROW_LIMIT = IDX_W'(MAX_HEIGHT - 1);

  logic [SUM_W-1:0] row_sum, row_sum_next;
  logic [IDX_W-1:0] row_index, row_index_next;
  logic [IDX_W-1:0] strong_rows, strong_rows_next;
  logic [IDX_W-1:0] medium_rows, medium_rows_next;

  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             in_roi;
  logic             is_strong;
  logic             is_medium;
  logic             closing;
  logic [IDX_W-1:0] strong_upd;
  logic [IDX_W-1:0] medium_upd;
  logic [IDX_W-1:0] index_inc;

  always_comb begin
    sum_wide  = {1'b0, row_sum} + (SUM_W + 1)'(item.pixel);
    sum_sat   = (sum_wide > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum_wide[SUM_W-1:0];
    in_roi    = CMPI_W'(row_index) >= CMPI_W'(cfg.roi_first_row);
    is_strong = in_roi && (CMPS_W'(sum_sat) > CMPS_W'(cfg.high_threshold));
    is_medium = in_roi && !is_strong && (CMPS_W'(sum_sat) > CMPS_W'(cfg.mid_threshold));
    closing   = item.row_end || item.frame_end;

    index_inc  = (row_index < ROW_LIMIT) ? row_index + IDX_W'(1) : ROW_LIMIT;
    strong_upd = strong_rows;
    medium_upd = medium_rows;
    if (closing && is_strong && strong_rows < ROW_LIMIT) begin
      strong_upd = strong_rows + IDX_W'(1);
    end
    if (closing && is_medium && medium_rows < ROW_LIMIT) begin
      medium_upd = medium_rows + IDX_W'(1);
    end

    row_sum_next     = row_sum;
    row_index_next   = row_index;
    strong_rows_next = strong_rows;
    medium_rows_next = medium_rows;
    if (step) begin
      priority if (item.frame_end) begin
        row_sum_next     = '0;
        row_index_next   = '0;
        strong_rows_next = '0;
        medium_rows_next = '0;
      end else if (item.row_end) begin
        row_sum_next     = '0;
        row_index_next   = index_inc;
        strong_rows_next = strong_upd;
        medium_rows_next = medium_upd;
      end else begin
        row_sum_next = sum_sat;
      end
    end

    // counts including the row closed by the frame end
    stat.done           = step && item.frame_end;
    stat.strong_one_two = (strong_upd == IDX_W'(1)) || (strong_upd == IDX_W'(2));
    stat.medium_le_two  = medium_upd <= IDX_W'(2);
    stat.medium_ge_four = medium_upd >= IDX_W'(4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum     <= '0;
      row_index   <= '0;
      strong_rows <= '0;
      medium_rows <= '0;
    end else begin
      row_sum     <= row_sum_next;
      row_index   <= row_index_next;
      strong_rows <= strong_rows_next;
      medium_rows <= medium_rows_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/hled_decide.sv -----
// ----------------------------------------------------------------------------
// hled_decide
// per-frame event decision, cooldown counter and result register
// ----------------------------------------------------------------------------
`default_nettype none

module hled_decide (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hled_pkg::frame_stat_t stat,
  input  wire logic [hled_pkg::COOLDOWN_W-1:0] cooldown_frames,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 event_code,
  output logic                       out_free
);

  logic [hled_pkg::COOLDOWN_W-1:0] cooldown_left, cooldown_left_next;
  logic [hled_pkg::COOLDOWN_W-1:0] cd_dec;
  hled_pkg::event_code_t           code;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cd_dec = (cooldown_left != '0) ? cooldown_left - (hled_pkg::COOLDOWN_W)'(1) : cooldown_left;
    code   = hled_pkg::EV_NONE;
    if (cd_dec == '0) begin
      priority if (stat.strong_one_two && stat.medium_le_two) begin
        code = hled_pkg::EV_THIN_LINE;
      end else if (stat.medium_ge_four) begin
        code = hled_pkg::EV_WIDE_BAND;
      end else begin
        code = hled_pkg::EV_NONE;
      end
    end
    cooldown_left_next = cooldown_left;
    if (stat.done) begin
      cooldown_left_next = (code != hled_pkg::EV_NONE) ? cooldown_frames : cd_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cooldown_left <= '0;
      out_valid     <= 1'b0;
    end else begin
      cooldown_left <= cooldown_left_next;
      if (stat.done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      event_code <= code;
    end
  end

endmodule

`default_nettype wire

// ----- src/horizontal_line_event_detector_top.sv -----
// ----------------------------------------------------------------------------
// horizontal_line_event_detector_top
// counts strong and medium mask rows per frame and reports line events
// ----------------------------------------------------------------------------
// usage:
//   pixel items enter on in_valid / in_ready in raster order; row_end marks
//   the last pixel of a row, frame_end the last pixel of the frame (it also
//   closes the row). one event_code item leaves on out_valid / out_ready for
//   every frame end: 0 none, 1 thin crossing line, 2 wide horizontal band
// path: a frame end is taken into the input register and, once it leaves
//   it, its event code is written into the result register, where out_valid
//   rises (input register, then result register)
// throughput: one pixel per cycle while no frame end is held, set by the
//   single add / compare path between the input register and row registers
// stall: pixels that do not end a frame keep flowing while a result waits;
//   a frame end is held in the input register until the result register is
//   free, and in_ready drops behind it
// reset: synchronous; clears row state, counters, cooldown and valids and
//   loads the configuration defaults (first row 320, thresholds 352 / 256,
//   cooldown 45); cfg_ready is always high, write only while idle
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_line_event_detector_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // pixel channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    pixel,
  input  wire logic                          row_end,
  input  wire logic                          frame_end,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         event_code,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hled_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hled_pkg::CFG_DATA_W-1:0]  cfg_data
);

  hled_pkg::cfg_t        cfg;
  hled_pkg::pixel_item_t in_item;
  hled_pkg::pixel_item_t stage_item;
  hled_pkg::frame_stat_t stat;
  logic                  step;
  logic                  out_free;

  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_first_row   <= hled_pkg::ROI_FIRST_ROW_RESET;
      cfg.high_threshold  <= hled_pkg::HIGH_THRESHOLD_RESET;
      cfg.mid_threshold   <= hled_pkg::MID_THRESHOLD_RESET;
      cfg.cooldown_frames <= hled_pkg::COOLDOWN_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hled_pkg::CFG_ROI_FIRST_ROW: begin
          cfg.roi_first_row <= cfg_data[hled_pkg::ROW_CFG_W-1:0];
        end
        hled_pkg::CFG_HIGH_THRESHOLD: begin
          cfg.high_threshold <= cfg_data[hled_pkg::THR_W-1:0];
        end
        hled_pkg::CFG_MID_THRESHOLD: begin
          cfg.mid_threshold <= cfg_data[hled_pkg::THR_W-1:0];
        end
        hled_pkg::CFG_COOLDOWN_FRAMES: begin
          cfg.cooldown_frames <= cfg_data[hled_pkg::COOLDOWN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign in_item.pixel     = pixel;
  assign in_item.row_end   = row_end;
  assign in_item.frame_end = frame_end;

  // input register
  hled_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_free   (out_free),
    .stage_item (stage_item),
    .step       (step)
  );

  // row accumulation and classification
  hled_row_acc #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_row_acc (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (stage_item),
    .cfg  (cfg),
    .stat (stat)
  );

  // frame decision and result register
  hled_decide u_decide (
    .clk             (clk),
    .rst             (rst),
    .stat            (stat),
    .cooldown_frames (cfg.cooldown_frames),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_code      (event_code),
    .out_free        (out_free)
  );

endmodule

`default_nettype wire
